FILE: sv/sfkr_pkg.sv
// Shared types and constants for the searchable FIFO with keyed removal.
// No dependencies; every other file of the block refers to it by scoped names.
package sfkr_pkg;

  // Item field widths on the channels
  localparam int CMD_W  = 3;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  // Defaults for the top level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int KEY_WIDTH_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_FRONT  = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_REMOVE = 3'd4
  } cmd_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture the accepted item, clear result
    logic exec;       // first step of the command
    logic scan_step;  // consume one read entry during a scan
    logic post;       // load the result into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;  // command walks the queue
    logic scan_done;  // current scan step is the last one
    logic out_free;   // output register can take a result
  } ctl_stat_t;

endpackage

FILE: sv/sfkr_if.sv
// Channel interfaces: command items in, result items out.
// Depends on sfkr_pkg for field widths.
interface sfkr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [sfkr_pkg::CMD_W-1:0]  command;
  logic [sfkr_pkg::KEY_W-1:0]  key;
  logic [sfkr_pkg::DATA_W-1:0] payload;

  modport source (output valid, command, key, payload, input ready);
  modport sink   (input valid, command, key, payload, output ready);
endinterface

interface sfkr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [sfkr_pkg::DATA_W-1:0] data_out;
  logic [sfkr_pkg::CNT_W-1:0]  removed_count;
  logic [sfkr_pkg::CNT_W-1:0]  occupancy;
  logic                        is_empty;
  logic [sfkr_pkg::STAT_W-1:0] status;

  modport source (output valid, hit, data_out, removed_count, occupancy, is_empty, status,
                  input ready);
  modport sink   (input valid, hit, data_out, removed_count, occupancy, is_empty, status,
                  output ready);
endinterface

FILE: sv/searchable_fifo_keyed_remove_top.sv
// Searchable FIFO with keyed removal. Push, pop and unused codes pass from accept
// through the execute and post states to the result. Front, find and remove add a scan
// step per entry examined (up to the occupancy) through the single-read-port entry store.
// A new item is accepted once the previous result sits in the output register.
// Synchronous reset empties the queue and the output register; the entry store
// itself is not cleared.
module searchable_fifo_keyed_remove_top #(
  parameter int DEPTH      = sfkr_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH  = sfkr_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = sfkr_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sfkr_cmd_if.sink    cmd,
  sfkr_rsp_if.source  rsp
);

  sfkr_pkg::ctl_cmd_t  ctl;
  sfkr_pkg::ctl_stat_t stat;
  logic                in_ready;

  assign cmd.ready = in_ready;

  sfkr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  sfkr_dpath #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (KEY_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .command (cmd.command),
    .key     (cmd.key),
    .payload (cmd.payload),
    .ctl     (ctl),
    .stat    (stat),
    .rsp     (rsp)
  );

endmodule

FILE: sv/sfkr_ctrl.sv
// Sequencer for the searchable FIFO: accept, execute, scan, post result.
// Depends on sfkr_pkg for the command and status structs.
module sfkr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfkr_pkg::ctl_stat_t  stat,
  output sfkr_pkg::ctl_cmd_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POST
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    ctl           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = stat.need_scan ? S_SCAN : S_POST;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_POST;
      end
      S_POST: begin
        if (stat.out_free) begin
          ctl.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/sfkr_dpath.sv
// Datapath: ring-buffer entry store, scan and compaction logic, result register.
// Depends on sfkr_pkg and the result channel interface.
module sfkr_dpath #(
  parameter int DEPTH      = sfkr_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH  = sfkr_pkg::KEY_WIDTH_DEF,
  parameter int DATA_WIDTH = sfkr_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sfkr_pkg::CMD_W-1:0]  command,
  input  logic [sfkr_pkg::KEY_W-1:0]  key,
  input  logic [sfkr_pkg::DATA_W-1:0] payload,
  input  sfkr_pkg::ctl_cmd_t          ctl,
  output sfkr_pkg::ctl_stat_t         stat,
  sfkr_rsp_if.source                  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Entry store
  logic [KEY_WIDTH-1:0]  mem_k [DEPTH];
  logic [DATA_WIDTH-1:0] mem_p [DEPTH];
  logic [KEY_WIDTH-1:0]  rd_k;
  logic [DATA_WIDTH-1:0] rd_p;

  // Queue and per-command state
  logic [AW-1:0]         head;
  logic [CW-1:0]         count;
  sfkr_pkg::cmd_code_t   cmd_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [DATA_WIDTH-1:0] pay_r;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         widx;
  logic                  hit_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [CW-1:0]         rem_r;
  sfkr_pkg::status_t     stat_r;

  // Result register
  logic                        out_valid;
  logic                        out_hit;
  logic [sfkr_pkg::DATA_W-1:0] out_data;
  logic [sfkr_pkg::CNT_W-1:0]  out_rem;
  logic [sfkr_pkg::CNT_W-1:0]  out_occ;
  logic                        out_empty;
  sfkr_pkg::status_t           out_stat;

  // Memory port controls
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [KEY_WIDTH-1:0]  wkey;
  logic [DATA_WIDTH-1:0] wpay;
  logic                  re;
  logic [AW-1:0]         raddr;

  logic match;
  logic last;
  logic scan_done;
  logic is_scan_cmd;
  logic [31:0] key_ext;
  logic [63:0] pay_ext;
  logic [63:0] data_ext;
  logic [15:0] rem_ext;
  logic [15:0] occ_ext;

  // Physical address of logical position off behind the head
  function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign key_ext = 32'(key);
  assign pay_ext = 64'(payload);

  assign is_scan_cmd = (cmd_r == sfkr_pkg::CMD_FRONT) || (cmd_r == sfkr_pkg::CMD_FIND) ||
                       (cmd_r == sfkr_pkg::CMD_REMOVE);
  assign match     = (cmd_r == sfkr_pkg::CMD_FRONT) || (rd_k == key_r);
  assign last      = (idx == count);
  assign scan_done = last || ((cmd_r != sfkr_pkg::CMD_REMOVE) && match);

  assign stat.need_scan = is_scan_cmd && (count != '0);
  assign stat.scan_done = scan_done;
  assign stat.out_free  = !out_valid || rsp.ready;

  // Memory write and read port selection
  always_comb begin
    we    = 1'b0;
    waddr = wrap_addr(head, count);
    wkey  = key_r;
    wpay  = pay_r;
    re    = 1'b0;
    raddr = head;
    if (ctl.exec) begin
      if (cmd_r == sfkr_pkg::CMD_PUSH && count != FULL_CNT) we = 1'b1;
      if (is_scan_cmd && count != '0) re = 1'b1;
    end
    if (ctl.scan_step) begin
      if (cmd_r == sfkr_pkg::CMD_REMOVE && !match) begin
        we    = 1'b1;
        waddr = wrap_addr(head, widx);
        wkey  = rd_k;
        wpay  = rd_p;
      end
      if (!scan_done) begin
        re    = 1'b1;
        raddr = wrap_addr(head, idx);
      end
    end
  end

  // Entry store write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_k[waddr] <= wkey;
      mem_p[waddr] <= wpay;
    end
  end

  // Entry store read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rd_k <= mem_k[raddr];
      rd_p <= mem_p[raddr];
    end
  end

  // Queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      if (cmd_r == sfkr_pkg::CMD_PUSH && count != FULL_CNT) begin
        count <= count + 1'b1;
      end else if (cmd_r == sfkr_pkg::CMD_POP && count != '0) begin
        head  <= (head == LAST_ADDR) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end else if (ctl.scan_step && cmd_r == sfkr_pkg::CMD_REMOVE && last) begin
      count <= match ? widx : widx + 1'b1;
    end
  end

  // Command capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= sfkr_pkg::cmd_code_t'(command);
      key_r  <= key_ext[KEY_WIDTH-1:0];
      pay_r  <= pay_ext[DATA_WIDTH-1:0];
      hit_r  <= 1'b0;
      data_r <= '0;
      rem_r  <= '0;
      stat_r <= sfkr_pkg::ST_OK;
    end
    if (ctl.exec) begin
      idx  <= CW'(1);
      widx <= '0;
      case (cmd_r) inside
        sfkr_pkg::CMD_PUSH:  if (count == FULL_CNT) stat_r <= sfkr_pkg::ST_FULL;
        sfkr_pkg::CMD_POP,
        sfkr_pkg::CMD_FRONT: if (count == '0) stat_r <= sfkr_pkg::ST_EMPTY;
        default: ;
      endcase
    end
    if (ctl.scan_step) begin
      if (!scan_done) idx <= idx + 1'b1;
      if (match) begin
        hit_r  <= 1'b1;
        data_r <= rd_p;
        if (cmd_r == sfkr_pkg::CMD_REMOVE) rem_r <= rem_r + 1'b1;
      end else if (cmd_r == sfkr_pkg::CMD_REMOVE) begin
        widx <= widx + 1'b1;
      end
    end
  end

  assign data_ext = 64'(data_r);
  assign rem_ext  = 16'(rem_r);
  assign occ_ext  = 16'(count);

  // Result register; the next command may run while this waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.post) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (ctl.post) begin
      out_hit   <= hit_r;
      out_data  <= data_ext[sfkr_pkg::DATA_W-1:0];
      out_rem   <= rem_ext[sfkr_pkg::CNT_W-1:0];
      out_occ   <= occ_ext[sfkr_pkg::CNT_W-1:0];
      out_empty <= (count == '0);
      out_stat  <= stat_r;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.data_out      = out_data;
  assign rsp.removed_count = out_rem;
  assign rsp.occupancy     = out_occ;
  assign rsp.is_empty      = out_empty;
  assign rsp.status        = out_stat;

endmodule
